FILE: hdl/trwp_pkg.sv
// Shared types and constants of the timed register write player.
package trwp_pkg;

    localparam int MAX_EVENTS_DEF          = 4096;
    localparam int MAX_WRITES_PER_TICK_DEF = 64;

    localparam int EVENT_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int TRACK_W    = 13;
    localparam int TICKS_W    = 32;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ENABLE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_EVENTS = 1'd1;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] event_index;
        logic [7:0]  event_reg;
        logic [7:0]  event_value;
        logic [15:0] event_delay;
    } item_t;

    typedef struct packed {
        logic       has_write;
        logic [7:0] reg_addr;
        logic [7:0] reg_value;
        logic       last;
    } result_t;

endpackage

FILE: hdl/trwp_track_mem.sv
// Track memory: one write port, one registered read port.
module trwp_track_mem #(
    parameter int DEPTH  = trwp_pkg::MAX_EVENTS_DEF,
    parameter int ADDR_W = 12
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            waddr,
    input  logic [trwp_pkg::EVENT_W-1:0] wdata,
    input  logic [ADDR_W-1:0]            raddr,
    output logic [trwp_pkg::EVENT_W-1:0] rdata
);

    logic [trwp_pkg::EVENT_W-1:0] store_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= store_mem[raddr];
    end

endmodule

FILE: hdl/timed_register_write_player.sv
// Top level of the timed register write player.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  command   | start / busy              | item   (cmd, index, reg, value, delay)
//  result    | result_valid strobe       | result (has_write, addr, value, last)
//  config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A command beat is taken when start is high and busy is low. Load and restart
// give no result. A tick with nothing due, or with playback held, gives its
// single result the next cycle and leaves busy low. A tick that walks events
// keeps busy high while it walks: the first event is read as the tick is
// taken, then one event read and one result per cycle through the track
// memory's single read port; the last result shows as busy drops.
// Reset clears position, both clocks and the config registers; the track memory is
// not cleared. Results cannot be stalled; cfg_ready is low while walking.
module timed_register_write_player #(
    parameter int MAX_EVENTS          = trwp_pkg::MAX_EVENTS_DEF,
    parameter int MAX_WRITES_PER_TICK = trwp_pkg::MAX_WRITES_PER_TICK_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  trwp_pkg::item_t                 item,
    output logic                            result_valid,
    output trwp_pkg::result_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [trwp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trwp_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int POS_W = $clog2(MAX_EVENTS + 1);
    // common compare width for position, length and load index
    localparam int W     = (POS_W > trwp_pkg::TRACK_W) ? POS_W : trwp_pkg::TRACK_W;
    localparam int CNT_W = $clog2(MAX_WRITES_PER_TICK + 1);
    localparam int TW    = trwp_pkg::TICKS_W;

    localparam logic [W-1:0]     MAX_EV_W  = W'(MAX_EVENTS);
    localparam logic [CNT_W-1:0] MAX_WR_C  = CNT_W'(MAX_WRITES_PER_TICK);

    trwp_pkg::state_t state_reg, state_next;

    logic [POS_W-1:0]             position_reg, position_next;
    logic [TW-1:0]                now_reg, now_next;
    logic [TW-1:0]                due_reg, due_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         play_enable_reg;
    logic [trwp_pkg::TRACK_W-1:0] track_events_reg;
    logic                         result_valid_reg, result_valid_next;
    trwp_pkg::result_t            result_reg, result_next;

    logic                         accept;
    logic                         walk_start;
    logic                         walk_last;
    logic                         mem_we;
    logic [trwp_pkg::EVENT_W-1:0] mem_wdata;
    logic [trwp_pkg::EVENT_W-1:0] mem_rdata;
    logic [W-1:0]                 len;
    logic [W-1:0]                 track_ext;
    logic [W-1:0]                 pos_ext;
    logic [W-1:0]                 pos_inc_ext;
    logic [W-1:0]                 idx_ext;
    logic [POS_W-1:0]             pos_inc;
    logic [CNT_W-1:0]             cnt_inc;
    logic [TW-1:0]                due_sum;
    logic                         nothing_due;

    // ---------------------------------------------------------------- track memory
    assign mem_wdata = {item.event_delay, item.event_value, item.event_reg};

    trwp_track_mem #(
        .DEPTH  (MAX_EVENTS),
        .ADDR_W (IDX_W)
    ) u_track_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_ext[IDX_W-1:0]),
        .wdata (mem_wdata),
        .raddr (position_next[IDX_W-1:0]),  // data is ready for the next cycle
        .rdata (mem_rdata)
    );

    // ---------------------------------------------------------------- decode
    assign accept    = start && !busy;
    assign track_ext = W'(track_events_reg);
    assign len       = (track_ext > MAX_EV_W) ? MAX_EV_W : track_ext;
    assign pos_ext   = W'(position_reg);
    assign idx_ext   = W'(item.event_index);
    assign pos_inc   = position_reg + 1'b1;
    assign pos_inc_ext = W'(pos_inc);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign due_sum   = due_reg + TW'(mem_rdata[31:16]);

    assign nothing_due = (pos_ext >= len) || (due_reg > now_reg);
    assign walk_start  = accept && (item.cmd == trwp_pkg::CMD_TICK) && play_enable_reg
                         && !nothing_due;
    // the walk ends after this event when the track runs out, the per-tick
    // budget is spent, or the following event is not yet due
    assign walk_last   = (pos_inc_ext >= len) || (cnt_inc == MAX_WR_C) || (due_sum > now_reg);

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trwp_pkg::ST_IDLE:
            begin
                if (walk_start)
                begin
                    state_next = trwp_pkg::ST_WALK;
                end
            end
            trwp_pkg::ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = trwp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = trwp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != trwp_pkg::ST_IDLE);
        cfg_ready = (state_reg == trwp_pkg::ST_IDLE);
    end

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        position_next     = position_reg;
        now_next          = now_reg;
        due_next          = due_reg;
        cnt_next          = cnt_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        mem_we            = 1'b0;

        case (state_reg)
            trwp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.cmd)
                        trwp_pkg::CMD_LOAD:
                        begin
                            mem_we = (idx_ext < MAX_EV_W);
                        end
                        trwp_pkg::CMD_TICK:
                        begin
                            if (walk_start)
                            begin
                                cnt_next = '0;
                            end
                            else
                            begin
                                // single empty result
                                result_valid_next     = 1'b1;
                                result_next.has_write = 1'b0;
                                result_next.reg_addr  = '0;
                                result_next.reg_value = '0;
                                result_next.last      = 1'b1;
                                if (play_enable_reg)
                                begin
                                    now_next = now_reg + 1'b1;
                                    if (pos_ext >= len)
                                    begin
                                        position_next = '0;
                                        now_next      = '0;
                                        due_next      = '0;
                                    end
                                end
                            end
                        end
                        trwp_pkg::CMD_RESTART:
                        begin
                            position_next = '0;
                            now_next      = '0;
                            due_next      = '0;
                        end
                        default:
                        begin
                            // unused code, ignored
                        end
                    endcase
                end
            end
            trwp_pkg::ST_WALK:
            begin
                result_valid_next     = 1'b1;
                result_next.has_write = 1'b1;
                result_next.reg_addr  = mem_rdata[7:0];
                result_next.reg_value = mem_rdata[15:8];
                result_next.last      = walk_last;
                due_next              = due_sum;
                position_next         = pos_inc;
                cnt_next              = cnt_inc;
                if (walk_last)
                begin
                    now_next = now_reg + 1'b1;
                    if (pos_inc_ext >= len)
                    begin
                        position_next = '0;
                        now_next      = '0;
                        due_next      = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= trwp_pkg::ST_IDLE;
            position_reg     <= '0;
            now_reg          <= '0;
            due_reg          <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            play_enable_reg  <= 1'b0;
            track_events_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            position_reg     <= position_next;
            now_reg          <= now_next;
            due_reg          <= due_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    trwp_pkg::CFG_PLAY_ENABLE:  play_enable_reg  <= cfg_data[0];
                    trwp_pkg::CFG_TRACK_EVENTS: track_events_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------------------------------------------------------- checks
    a_write_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.has_write |-> $past(state_reg == trwp_pkg::ST_WALK))
        else $error("write result without an event walk");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_write |-> result.last)
        else $error("empty result not marked last");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("still busy after the last result of a tick");

    a_walk_in_track: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (pos_ext < len) && (cnt_reg < MAX_WR_C))
        else $error("walk past the track end or write budget");

    a_walk_emits: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_valid && result.has_write)
        else $error("walk cycle gave no write result");

endmodule
